/* design/sitoa_pkg.sv */
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
`default_nettype none

package sitoa_pkg;

  // input value and magnitude width
  localparam int unsigned VALUE_W = 32;
  // width of decimal thresholds (nine times one thousand million needs 34 bits)
  localparam int unsigned THR_W   = 34;
  // digit position index, 0 to 9 (and 10 for the bound above the top digit)
  localparam int unsigned POS_W   = 4;
  localparam int unsigned DIGITS  = 10;
  // queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // powers of ten, 10^0 to 10^10
  localparam logic [THR_W-1:0] POW10 [DIGITS+1] = '{
    34'd1,
    34'd10,
    34'd100,
    34'd1000,
    34'd10000,
    34'd100000,
    34'd1000000,
    34'd10000000,
    34'd100000000,
    34'd1000000000,
    34'd10000000000
  };

  // one classified request as held in the queue
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [POS_W-1:0]   top_pos;
  } q_entry_t;

endpackage

`default_nettype wire

/* design/sitoa_front.sv */
// ----------------------------------------------------------------------------
// sitoa_front
// Accepts requests, forms sign and magnitude and finds the leading digit.
// ----------------------------------------------------------------------------
`default_nettype none

module sitoa_front (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sitoa_pkg::VALUE_W-1:0] value_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output sitoa_pkg::q_entry_t                q_data_o
);

  logic                          neg;
  logic [sitoa_pkg::VALUE_W-1:0] mag;
  logic [sitoa_pkg::POS_W-1:0]   top_pos;

  // handshake towards the queue
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // sign and magnitude, the most negative value wraps to 2^31 unsigned
  assign neg = value_i[sitoa_pkg::VALUE_W-1];
  assign mag = neg ? (sitoa_pkg::VALUE_W'(0) - value_i) : value_i;

  // leading digit position: number of powers of ten from 10^1 to 10^9 not above the magnitude
  always_comb begin
    top_pos = '0;
    for (int k = 1; k < sitoa_pkg::DIGITS; k++) begin
      top_pos = top_pos + sitoa_pkg::POS_W'(
        {{(sitoa_pkg::THR_W-sitoa_pkg::VALUE_W){1'b0}}, mag} >= sitoa_pkg::POW10[k]);
    end
  end

  assign q_data_o = '{neg: neg, mag: mag, top_pos: top_pos};

endmodule

`default_nettype wire

/* design/sitoa_fifo.sv */
// ----------------------------------------------------------------------------
// sitoa_fifo
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sitoa_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sitoa_pkg::q_entry_t push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output sitoa_pkg::q_entry_t      pop_data_o
);

  sitoa_pkg::q_entry_t              mem_q [sitoa_pkg::QDEPTH];
  logic [sitoa_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sitoa_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sitoa_pkg::QCNT_W-1:0]     count_q, count_d;

  assign full_o     = (count_q == sitoa_pkg::QCNT_W'(sitoa_pkg::QDEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == sitoa_pkg::QPTR_W'(sitoa_pkg::QDEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == sitoa_pkg::QPTR_W'(sitoa_pkg::QDEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* design/sitoa_back.sv */
// ----------------------------------------------------------------------------
// sitoa_back
// Emits sign and digits of one request, most significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module sitoa_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire sitoa_pkg::q_entry_t q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               character_o,
  output logic                     last_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } back_state_e;

  back_state_e                   state_q, state_d;
  logic [sitoa_pkg::VALUE_W-1:0] rem_q, rem_d;
  logic [sitoa_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    char_q, char_d;
  logic                          last_q, last_d;

  logic                          can_emit;
  logic [sitoa_pkg::THR_W-1:0]   thr [9];
  logic [8:0]                    ge;
  logic [3:0]                    digit;
  logic [sitoa_pkg::THR_W-1:0]   sub;

  assign can_emit = !out_valid_q || out_ready_i;

  // multiples of the current power of ten, compared against the remainder
  always_comb begin
    for (int d = 1; d <= 9; d++) begin
      thr[d-1] = '0;
      for (int p = 0; p < sitoa_pkg::DIGITS; p++) begin
        if (pos_q == sitoa_pkg::POS_W'(p)) begin
          thr[d-1] = sitoa_pkg::THR_W'(sitoa_pkg::POW10[p] * sitoa_pkg::THR_W'(d));
        end
      end
      ge[d-1] = {{(sitoa_pkg::THR_W-sitoa_pkg::VALUE_W){1'b0}}, rem_q} >= thr[d-1];
    end
  end

  // digit is the number of multiples reached, the largest one is removed
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int d = 0; d < 9; d++) begin
      digit = digit + 4'(ge[d]);
      if (ge[d]) begin
        sub = thr[d];
      end
    end
  end

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rem_d   = q_data_i.mag;
          pos_d   = q_data_i.top_pos;
          state_d = q_data_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          char_d      = sitoa_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          char_d      = sitoa_pkg::CHAR_ZERO + {4'b0000, digit};
          last_d      = (pos_q == '0);
          rem_d       = rem_q - sub[sitoa_pkg::VALUE_W-1:0];
          if (pos_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // checks
  a_rem_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |->
      ({{(sitoa_pkg::THR_W-sitoa_pkg::VALUE_W){1'b0}}, rem_q} <
       sitoa_pkg::POW10[pos_q + 1'b1]))
    else $error("remainder exceeds current digit range");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT && can_emit && pos_q == '0) |=>
      (state_q == ST_IDLE && out_valid_o && last_o))
    else $error("final digit did not close the request");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN && can_emit) |=> (out_valid_o && !last_o))
    else $error("minus sign flagged as last");

endmodule

`default_nettype wire

/* design/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each request carries one two's complement value; the block returns its
// decimal text one character per response, most significant first, with a
// leading '-' for negative values, no leading zeros, '0' for zero and the
// last flag on the final character. The front takes a request in the cycle
// it arrives, as long as the two-entry queue has room. The back takes a
// request from the queue while idle and then emits its 1 to 11 characters
// before it takes the next; the digit unit finds one digit a cycle while
// the response is not stalled, by comparing the remainder against the
// nine multiples of the current power of ten and subtracting the largest
// one reached. A stalled response holds the back while the front keeps
// filling the queue.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sitoa_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [7:0]                         character_o,
  output logic                               last_o
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  sitoa_pkg::q_entry_t q_wdata;
  sitoa_pkg::q_entry_t q_rdata;

  // request intake and classification
  sitoa_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // decoupling queue
  sitoa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // character generation
  sitoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

/* bench/signed_int_to_decimal_ascii_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed 32-bit values into the converter and checks every returned
// character and last flag against a predicted decimal text, with random
// gaps on the request side and random stalls on the character side.
// ----------------------------------------------------------------------------

// one character of predicted text
typedef struct {
  logic [7:0] code;
  logic       last;
} text_char_t;

// holds the predicted text of every accepted request, oldest first
class ascii_scoreboard;
  text_char_t  expected_chars[$];
  int unsigned errors;
  int unsigned char_count;

  function new();
    errors     = 0;
    char_count = 0;
  endfunction

  task report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // predict the decimal text of one accepted request
  function void note_value(input logic [sitoa_pkg::VALUE_W-1:0] value);
    logic [sitoa_pkg::VALUE_W-1:0] mag;
    logic [3:0]                    digit_buf [10];
    int                            ndig;
    int                            k;
    text_char_t                    c;

    mag  = value[sitoa_pkg::VALUE_W-1] ? (32'd0 - value) : value;
    ndig = 0;
    do begin
      digit_buf[ndig] = 4'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    if (value[sitoa_pkg::VALUE_W-1]) begin
      c.code = sitoa_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (k = ndig - 1; k >= 0; k--) begin
      c.code = sitoa_pkg::CHAR_ZERO + {4'd0, digit_buf[k]};
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // compare one returned character with the oldest prediction
  task check_char(input logic [7:0] code, input logic last);
    text_char_t want;
    if (expected_chars.size() == 0) begin
      report($sformatf("character %0d: unexpected %h last %b", char_count, code, last));
    end else begin
      want = expected_chars.pop_front();
      if (code !== want.code)
        report($sformatf("character %0d: code %h, expected %h",
                         char_count, code, want.code));
      if (last !== want.last)
        report($sformatf("character %0d: last %b, expected %b",
                         char_count, last, want.last));
    end
    char_count++;
  endtask

  function int unsigned pending();
    return expected_chars.size();
  endfunction
endclass

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned RANDOM_COUNT = 430;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [sitoa_pkg::VALUE_W-1:0] value_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [7:0]                    character_o;
  logic                          last_o;

  ascii_scoreboard sb;
  int unsigned     cycle_count = 0;
  bit              tx_burst    = 1'b0;
  bit              rx_burst    = 1'b0;
  int unsigned     stall_left  = 0;

  // edges of the range, zero, digit-count boundaries and bit patterns
  logic [sitoa_pkg::VALUE_W-1:0] directed_vals [] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'd9,
    32'd10,        -32'sd10,      32'd99,        32'd100,
    -32'sd9,       32'd999999999, 32'd1000000000, -32'sd999999999,
    -32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890,
    -32'sd1234567890, 32'd1000000, -32'sd100000, 32'd7
  };

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // random value, weighted towards every digit count and both signs
  function automatic logic [sitoa_pkg::VALUE_W-1:0] rand_value();
    longint lo;
    longint hi;
    int     ndig;
    int     k;
    logic [sitoa_pkg::VALUE_W-1:0] mag;

    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4, 5, 6: return $urandom();
      default: begin
        ndig = $urandom_range(1, 10);
        lo   = 1;
        for (k = 1; k < ndig; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = $urandom_range(32'(lo), 32'(hi));
        return ($urandom_range(0, 1) != 0) ? (32'd0 - mag) : mag;
      end
    endcase
  endfunction

  // hold one request until accepted, then maybe leave a gap
  task automatic send_value(input logic [sitoa_pkg::VALUE_W-1:0] value);
    int unsigned gap;
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_value(value);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // character side: check what is accepted, stall at random
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_char(character_o, last_o);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      if (stall_left == 0 && !rx_burst && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests
    foreach (directed_vals[i]) send_value(directed_vals[i]);

    // random requests
    repeat (RANDOM_COUNT) send_value(rand_value());
    in_valid_i <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0)
      $display("signed_int_to_decimal_ascii verification clean");
    else
      $display("signed_int_to_decimal_ascii verification failed");
    $finish;
  end

endmodule
